FILE: rtl/hcbc_pkg.sv
// shared types and constants for the huffman code builder and codec
`default_nettype none
package hcbc_pkg;
	localparam int MaxSymbols = 128;
	localparam int MaxCodeLen = 32;
	localparam int CodeLim = (MaxCodeLen < 32) ? MaxCodeLen : 32;
	localparam int NodeSlots = 2 * MaxSymbols;
	localparam int IdxW = $clog2(NodeSlots);
	localparam int LeafW = $clog2(MaxSymbols);
	localparam int CntW = $clog2(MaxSymbols + 1);

	localparam logic [1:0] ActLoad = 2'd0;
	localparam logic [1:0] ActEncode = 2'd1;
	localparam logic [1:0] ActDecode = 2'd2;

	typedef struct packed {
		logic [1:0] action;
		logic [6:0] symbol;
		logic [31:0] weight;
		logic last_entry;
		logic bit_req;
	} in_item_t;

	typedef struct packed {
		logic kind;
		logic [6:0] out_symbol;
		logic [31:0] code_bits;
		logic [5:0] code_length;
		logic too_long;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_SCAN_RD,
		ST_SCAN,
		ST_MERGE,
		ST_PATH_RD,
		ST_PATH_L,
		ST_PATH_R,
		ST_COPY_RD,
		ST_COPY,
		ST_ENC_RD,
		ST_ENC,
		ST_DEC_RD,
		ST_DEC,
		ST_DEC_SYM,
		ST_OUT
	} state_t;
endpackage
`default_nettype wire

FILE: rtl/huffman_code_build_and_codec.sv
// huffman tree builder, encoder and bit-serial decoder with a shared compare sequencer
// load: the last leaf adds the build: clear the parent flags, scan and merge for each internal node,
//   then hand down codes from the root, one internal node at a time, and finish
// encode: scan the leaves from the top, then present a result when the symbol is found
// decode: one step down the tree per bit, a symbol comes out at a leaf; one item at a time
// a result waits in the output register until taken; reset clears leaf count, tree flag, position
`default_nettype none
module huffman_code_build_and_codec (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire hcbc_pkg::in_item_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output hcbc_pkg::out_item_t out_data
);
	localparam int IW = hcbc_pkg::IdxW;
	localparam int LW = hcbc_pkg::LeafW;
	localparam int CW = hcbc_pkg::CntW;

	// node tables, one port each in use per cycle but the parent flags, written twice in a merge
	logic [39:0] wt_mem [hcbc_pkg::NodeSlots];
	logic [6:0] sym_mem [hcbc_pkg::MaxSymbols];
	logic [IW-1:0] left_mem [hcbc_pkg::NodeSlots];
	logic [IW-1:0] right_mem [hcbc_pkg::NodeSlots];
	logic [31:0] pbits_mem [hcbc_pkg::NodeSlots];
	logic [6:0] plen_mem [hcbc_pkg::NodeSlots];
	logic has_par_q [hcbc_pkg::NodeSlots];

	hcbc_pkg::state_t state_q, state_d;
	logic [CW-1:0] leaf_cnt_q;
	logic ready_q;
	logic [IW-1:0] dpos_q;
	logic [IW-1:0] i_q, j_q;
	logic [IW-1:0] m1_q, m2_q;
	logic m1v_q, m2v_q;
	logic [39:0] w1_q, w2_q;
	logic [39:0] wrd_q;
	logic par_rd_q;
	logic [IW-1:0] lrd_q, rrd_q;
	logic [31:0] pb_q;
	logic [6:0] pl_q;
	logic [6:0] srd_q;
	hcbc_pkg::in_item_t item_q;
	hcbc_pkg::out_item_t res_q;
	logic out_v_q;

	logic [IW-1:0] root;
	logic [IW-1:0] nleaf;
	logic [IW:0] total;
	assign nleaf = IW'(leaf_cnt_q);
	assign total = {nleaf, 1'b0} - (IW+1)'(1);
	assign root = IW'(total - (IW+1)'(1));

	assign in_ready = (state_q == hcbc_pkg::ST_IDLE) && !out_v_q;
	assign out_valid = out_v_q;
	assign out_data = res_q;

	// path values handed to a child
	logic [6:0] child_len;
	logic [31:0] child_bits_l, child_bits_r;
	assign child_len = (pl_q < 7'd127) ? pl_q + 7'd1 : 7'd127;
	assign child_bits_l = (pl_q < 7'd32) ? {pb_q[30:0], 1'b1} : pb_q;
	assign child_bits_r = (pl_q < 7'd32) ? {pb_q[30:0], 1'b0} : pb_q;

	// encode output shaping
	logic [5:0] held, olen;
	assign held = (pl_q < 7'd32) ? 6'(pl_q) : 6'd32;
	assign olen = (pl_q < 7'(hcbc_pkg::CodeLim)) ? 6'(pl_q) : 6'(hcbc_pkg::CodeLim);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hcbc_pkg::ST_IDLE: begin
				if (in_valid && in_ready) begin
					unique case (in_data.action)
						hcbc_pkg::ActLoad: begin
							if (in_data.last_entry)
								state_d = hcbc_pkg::ST_INIT;
						end
						hcbc_pkg::ActEncode: begin
							if (ready_q && leaf_cnt_q != '0)
								state_d = hcbc_pkg::ST_ENC_RD;
						end
						hcbc_pkg::ActDecode: begin
							if (ready_q && leaf_cnt_q != '0)
								state_d = hcbc_pkg::ST_DEC_RD;
						end
						default: state_d = hcbc_pkg::ST_IDLE;
					endcase
				end
			end
			hcbc_pkg::ST_INIT: begin
				if (leaf_cnt_q == '0)
					state_d = hcbc_pkg::ST_IDLE;
				else if (i_q == IW'(total - (IW+1)'(1)))
					state_d = (nleaf == IW'(1)) ? hcbc_pkg::ST_PATH_RD : hcbc_pkg::ST_SCAN_RD;
			end
			hcbc_pkg::ST_SCAN_RD: state_d = hcbc_pkg::ST_SCAN;
			hcbc_pkg::ST_SCAN: state_d = (j_q == i_q) ? hcbc_pkg::ST_MERGE
				: hcbc_pkg::ST_SCAN;
			hcbc_pkg::ST_MERGE: state_d = (i_q == root) ? hcbc_pkg::ST_PATH_RD
				: hcbc_pkg::ST_SCAN_RD;
			hcbc_pkg::ST_PATH_RD: state_d = (i_q < nleaf || nleaf == IW'(1))
				? hcbc_pkg::ST_COPY_RD : hcbc_pkg::ST_PATH_L;
			hcbc_pkg::ST_PATH_L: state_d = hcbc_pkg::ST_PATH_R;
			hcbc_pkg::ST_PATH_R: state_d = (i_q == nleaf) ? hcbc_pkg::ST_COPY_RD
				: hcbc_pkg::ST_PATH_RD;
			hcbc_pkg::ST_COPY_RD: state_d = hcbc_pkg::ST_COPY;
			hcbc_pkg::ST_COPY: state_d = hcbc_pkg::ST_IDLE;
			hcbc_pkg::ST_ENC_RD: state_d = hcbc_pkg::ST_ENC;
			hcbc_pkg::ST_ENC: begin
				if (srd_q == item_q.symbol)
					state_d = hcbc_pkg::ST_OUT;
				else if (j_q == '0)
					state_d = hcbc_pkg::ST_IDLE;
				else
					state_d = hcbc_pkg::ST_ENC_RD;
			end
			hcbc_pkg::ST_DEC_RD: state_d = (nleaf == IW'(1)) ? hcbc_pkg::ST_DEC_SYM
				: hcbc_pkg::ST_DEC;
			hcbc_pkg::ST_DEC: state_d = hcbc_pkg::ST_DEC_SYM;
			hcbc_pkg::ST_DEC_SYM: state_d = (j_q < nleaf) ? hcbc_pkg::ST_OUT
				: hcbc_pkg::ST_IDLE;
			hcbc_pkg::ST_OUT: state_d = hcbc_pkg::ST_IDLE;
			default: state_d = hcbc_pkg::ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hcbc_pkg::ST_IDLE;
			leaf_cnt_q <= '0;
			ready_q <= 1'b0;
			dpos_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_v_q && out_ready)
				out_v_q <= 1'b0;
			unique case (state_q)
				hcbc_pkg::ST_IDLE: begin
					if (in_valid && in_ready && in_data.action == hcbc_pkg::ActLoad) begin
						if (ready_q) begin
							ready_q <= 1'b0;
							leaf_cnt_q <= CW'(1);
						end else if (leaf_cnt_q < CW'(hcbc_pkg::MaxSymbols)) begin
							leaf_cnt_q <= leaf_cnt_q + CW'(1);
						end
					end
				end
				hcbc_pkg::ST_COPY: begin
					ready_q <= 1'b1;
					dpos_q <= root;
				end
				hcbc_pkg::ST_DEC_SYM: begin
					dpos_q <= (j_q < nleaf) ? root : j_q;
				end
				hcbc_pkg::ST_OUT: out_v_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// datapath and tables
	always_ff @(posedge clk) begin
		unique case (state_q)
			hcbc_pkg::ST_IDLE: begin
				if (in_valid && in_ready) begin
					item_q <= in_data;
					if (in_data.action == hcbc_pkg::ActLoad) begin
						if (ready_q) begin
							sym_mem[0] <= in_data.symbol;
							wt_mem[0] <= {8'd0, in_data.weight};
						end else if (leaf_cnt_q < CW'(hcbc_pkg::MaxSymbols)) begin
							sym_mem[LW'(leaf_cnt_q)] <= in_data.symbol;
							wt_mem[IW'(leaf_cnt_q)] <= {8'd0, in_data.weight};
						end
					end
					j_q <= nleaf - IW'(1);
					// decode resumes at the kept node, or at the root when it is a leaf or out of range
					if (in_data.action != hcbc_pkg::ActDecode)
						i_q <= '0;
					else if (dpos_q >= IW'(total) || dpos_q < nleaf)
						i_q <= root;
					else
						i_q <= dpos_q;
				end
			end
			hcbc_pkg::ST_INIT: begin
				has_par_q[i_q] <= 1'b0;
				if (i_q == IW'(total - (IW+1)'(1))) begin
					i_q <= (nleaf == IW'(1)) ? '0 : nleaf;
					j_q <= '0;
					m1v_q <= 1'b0;
					m2v_q <= 1'b0;
				end else begin
					i_q <= i_q + IW'(1);
				end
				pb_q <= '0;
				pl_q <= '0;
			end
			hcbc_pkg::ST_SCAN_RD: begin
				wrd_q <= wt_mem[j_q];
				par_rd_q <= has_par_q[j_q];
			end
			hcbc_pkg::ST_SCAN: begin
				// one compare pair per visited node that has no parent yet
				if (j_q != i_q) begin
					if (!par_rd_q) begin
						if (!m1v_q) begin
							m1_q <= j_q; w1_q <= wrd_q; m1v_q <= 1'b1;
						end else if (wrd_q < w1_q) begin
							m2_q <= m1_q; w2_q <= w1_q; m2v_q <= 1'b1;
							m1_q <= j_q; w1_q <= wrd_q;
						end else if (!m2v_q || wrd_q < w2_q) begin
							m2_q <= j_q; w2_q <= wrd_q; m2v_q <= 1'b1;
						end
					end
					j_q <= j_q + IW'(1);
					wrd_q <= wt_mem[j_q + IW'(1)];
					par_rd_q <= has_par_q[j_q + IW'(1)];
				end
			end
			hcbc_pkg::ST_MERGE: begin
				wt_mem[i_q] <= w1_q + w2_q;
				left_mem[i_q] <= m1_q;
				right_mem[i_q] <= m2_q;
				has_par_q[m1_q] <= 1'b1;
				has_par_q[m2_q] <= 1'b1;
				j_q <= '0;
				m1v_q <= 1'b0;
				m2v_q <= 1'b0;
				if (i_q == root) begin
					pbits_mem[root] <= '0;
					plen_mem[root] <= '0;
				end else begin
					i_q <= i_q + IW'(1);
				end
			end
			hcbc_pkg::ST_PATH_RD: begin
				if (nleaf == IW'(1)) begin
					pbits_mem[0] <= '0;
					plen_mem[0] <= '0;
				end
				pb_q <= pbits_mem[i_q];
				pl_q <= plen_mem[i_q];
				lrd_q <= left_mem[i_q];
				rrd_q <= right_mem[i_q];
				j_q <= '0;
			end
			hcbc_pkg::ST_PATH_L: begin
				pbits_mem[lrd_q] <= child_bits_l;
				plen_mem[lrd_q] <= child_len;
			end
			hcbc_pkg::ST_PATH_R: begin
				pbits_mem[rrd_q] <= child_bits_r;
				plen_mem[rrd_q] <= child_len;
				i_q <= i_q - IW'(1);
			end
			hcbc_pkg::ST_COPY_RD: ;
			hcbc_pkg::ST_COPY: ;
			hcbc_pkg::ST_ENC_RD: begin
				srd_q <= sym_mem[LW'(j_q)];
				pb_q <= pbits_mem[j_q];
				pl_q <= plen_mem[j_q];
			end
			hcbc_pkg::ST_ENC: begin
				j_q <= j_q - IW'(1);
				res_q.kind <= 1'b0;
				res_q.out_symbol <= item_q.symbol;
				res_q.code_bits <= pb_q >> (held - olen);
				res_q.code_length <= olen;
				res_q.too_long <= (pl_q > 7'(hcbc_pkg::CodeLim));
			end
			hcbc_pkg::ST_DEC_RD: begin
				j_q <= '0;
				lrd_q <= left_mem[i_q];
				rrd_q <= right_mem[i_q];
			end
			hcbc_pkg::ST_DEC: begin
				j_q <= item_q.bit_req ? lrd_q : rrd_q;
			end
			hcbc_pkg::ST_DEC_SYM: begin
				srd_q <= sym_mem[LW'(j_q)];
			end
			hcbc_pkg::ST_OUT: begin
				if (item_q.action == hcbc_pkg::ActDecode) begin
					res_q.kind <= 1'b1;
					res_q.out_symbol <= srd_q;
					res_q.code_bits <= '0;
					res_q.code_length <= '0;
					res_q.too_long <= 1'b0;
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire
